[hdl/sars_pkg.sv]
package sars_pkg;

    localparam int CODE_BITS  = 8;
    localparam int CODE_VALS  = 1 << CODE_BITS;
    localparam int PH_W       = 4;
    localparam int TICK_W     = 16;
    localparam int BCNT_W     = 4;
    localparam int UNITS_W    = 3;
    localparam int DIGIT_W    = 4;
    localparam int VOLT_W     = UNITS_W + 2 * DIGIT_W;

    localparam logic [PH_W-1:0] PH_IDLE       = 4'd0;
    localparam logic [PH_W-1:0] PH_SETTLE     = 4'd1;
    localparam logic [PH_W-1:0] PH_B1_LOW     = 4'd2;
    localparam logic [PH_W-1:0] PH_B1_HIGH    = 4'd3;
    localparam logic [PH_W-1:0] PH_B2_LOW     = 4'd4;
    localparam logic [PH_W-1:0] PH_B2_HIGH    = 4'd5;
    localparam logic [PH_W-1:0] PH_B3_LOW     = 4'd6;
    localparam logic [PH_W-1:0] PH_B3_HIGH    = 4'd7;
    localparam logic [PH_W-1:0] PH_EXTRA_HIGH = 4'd8;
    localparam logic [PH_W-1:0] PH_FALL       = 4'd9;
    localparam logic [PH_W-1:0] PH_D_HIGH     = 4'd10;
    localparam logic [PH_W-1:0] PH_D_LOW      = 4'd11;

    localparam logic [TICK_W-1:0] HALF_RESET = 16'd100;

    typedef logic [VOLT_W-1:0] t_volt_tbl [CODE_VALS];

    // code -> {units, tenths, hundredths} of code*500/256
    function automatic t_volt_tbl build_volt_tbl();
        t_volt_tbl t;
        int        v;
        for (int c = 0; c < CODE_VALS; c++) begin
            v    = c * 500 / CODE_VALS;
            t[c] = {UNITS_W'(v / 100), DIGIT_W'((v / 10) % 10), DIGIT_W'(v % 10)};
        end
        return t;
    endfunction

    localparam t_volt_tbl VOLT_TBL = build_volt_tbl();

endpackage

[hdl/sars_if.sv]
interface sars_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic channel;
    logic adc_data;
    modport source (output valid, output start_req, output channel, output adc_data,
                    input ready);
    modport sink   (input valid, input start_req, input channel, input adc_data,
                    output ready);
endinterface

interface sars_out_if;
    logic       valid;
    logic       ready;
    logic       cs_n;
    logic       sclk;
    logic       mux_data;
    logic       done_res;
    logic [7:0] code;
    logic [2:0] volts_units;
    logic [3:0] volts_tenths;
    logic [3:0] volts_hundredths;
    modport source (output valid, output cs_n, output sclk, output mux_data,
                    output done_res, output code, output volts_units,
                    output volts_tenths, output volts_hundredths, input ready);
    modport sink   (input valid, input cs_n, input sclk, input mux_data,
                    input done_res, input code, input volts_units,
                    input volts_tenths, input volts_hundredths, output ready);
endinterface

interface sars_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/serial_adc_read_sequencer.sv]
// Pin sequencer for an 8-bit serial converter read. Every input transfer is one tick:
// it carries the start request, the channel and the converter data pin, and yields
// exactly one output transfer with the pin levels for that tick, a done flag, the last
// code and its voltage as three decimal digits (code*500/256, truncated). One transfer is
// taken per clock cycle when ready; the whole tick update is a single pass of logic into
// the output register, which holds a result while the next transfer is already accepted
// when the sink takes it in the same cycle. The half period register may be written at
// any cycle through the config channel, which is always ready; a value of 0 acts as 1.
module serial_adc_read_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sars_cfg_if.sink    i_cfg,
    sars_in_if.sink     i_in,
    sars_out_if.source  o_out
);
    import sars_pkg::*;

    logic [TICK_W-1:0]    r_half;
    logic [PH_W-1:0]      r_phase,   n_phase;
    logic [TICK_W-1:0]    r_tick,    n_tick;
    logic [BCNT_W-1:0]    r_bcnt,    n_bcnt;
    logic [CODE_BITS-1:0] r_shift,   n_shift;
    logic                 r_chan,    n_chan;
    logic [CODE_BITS-1:0] r_held,    n_held;
    logic                 n_done;
    logic                 n_cs, n_clk, n_di;

    logic                 r_out_valid;
    logic                 r_cs, r_sclk, r_di, r_done;
    logic [CODE_BITS-1:0] r_code;
    logic [VOLT_W-1:0]    r_volt;

    logic [TICK_W-1:0]    half_eff;
    logic [TICK_W:0]      tick_inc;
    logic                 ph_over;
    logic                 accept;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign accept      = i_in.valid && i_in.ready;

    assign half_eff = (r_half == '0) ? TICK_W'(1) : r_half;
    assign tick_inc = {1'b0, r_tick} + (TICK_W+1)'(1);
    assign ph_over  = tick_inc >= {1'b0, half_eff};

    always_comb begin
        n_cs = 1'b0;
        n_clk = 1'b0;
        n_di = 1'b0;
        unique case (r_phase)
            PH_B1_HIGH:    begin n_clk = 1'b1; n_di = 1'b1;   end
            PH_B2_LOW:     n_di = 1'b1;
            PH_B2_HIGH:    begin n_clk = 1'b1; n_di = 1'b1;   end
            PH_B3_LOW:     n_di = 1'b1;
            PH_B3_HIGH:    begin n_clk = 1'b1; n_di = r_chan; end
            PH_EXTRA_HIGH: n_clk = 1'b1;
            PH_D_HIGH:     n_clk = 1'b1;
            PH_SETTLE, PH_B1_LOW, PH_FALL, PH_D_LOW: ;
            default:       n_cs = 1'b1;
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_bcnt  = r_bcnt;
        n_shift = r_shift;
        n_chan  = r_chan;
        n_held  = r_held;
        n_done  = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_in.start_req) begin
                    n_chan  = i_in.channel;
                    n_tick  = '0;
                    n_bcnt  = '0;
                    n_shift = '0;
                    n_phase = PH_SETTLE;
                end
            end
            PH_SETTLE, PH_B1_LOW, PH_B1_HIGH, PH_B2_LOW, PH_B2_HIGH, PH_B3_LOW,
            PH_B3_HIGH, PH_EXTRA_HIGH, PH_FALL, PH_D_HIGH: begin
                if (ph_over) begin
                    n_tick  = '0;
                    n_phase = (r_phase == PH_D_HIGH) ? PH_D_LOW : r_phase + PH_W'(1);
                end else begin
                    n_tick = tick_inc[TICK_W-1:0];
                end
            end
            PH_D_LOW: begin
                n_shift = {r_shift[CODE_BITS-2:0], i_in.adc_data};
                n_bcnt  = r_bcnt + BCNT_W'(1);
                n_tick  = '0;
                if (n_bcnt >= BCNT_W'(CODE_BITS)) begin
                    n_held  = n_shift;
                    n_done  = 1'b1;
                    n_bcnt  = '0;
                    n_phase = PH_IDLE;
                end else begin
                    n_phase = PH_D_HIGH;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_tick  = '0;
                n_bcnt  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= HALF_RESET;
        end else if (i_cfg.valid) begin
            r_half <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_bcnt      <= '0;
            r_shift     <= '0;
            r_chan      <= 1'b0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_tick  <= n_tick;
                r_bcnt  <= n_bcnt;
                r_shift <= n_shift;
                r_chan  <= n_chan;
                r_held  <= n_held;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cs   <= n_cs;
            r_sclk <= n_clk;
            r_di   <= n_di;
            r_done <= n_done;
            r_code <= n_held;
            r_volt <= VOLT_TBL[n_held];
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.cs_n             = r_cs;
    assign o_out.sclk             = r_sclk;
    assign o_out.mux_data         = r_di;
    assign o_out.done_res         = r_done;
    assign o_out.code             = r_code;
    assign o_out.volts_units      = r_volt[VOLT_W-1 -: UNITS_W];
    assign o_out.volts_tenths     = r_volt[2*DIGIT_W-1 -: DIGIT_W];
    assign o_out.volts_hundredths = r_volt[DIGIT_W-1:0];

endmodule
